// ----- rtl/ffc_pkg.sv -----
// ffc_pkg: grid geometry, cell word layout, state codes and neighbour offsets
// for the forest fire cell update block
// no dependencies
package ffc_pkg;

  // grid geometry (powers of two, so wrap-around is plain modular arithmetic)
  localparam int unsigned GRID_WIDTH  = 64;
  localparam int unsigned GRID_HEIGHT = 64;
  localparam int unsigned COL_W       = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W       = $clog2(GRID_HEIGHT);
  localparam int unsigned ADDR_W      = COL_W + ROW_W;
  localparam int unsigned CELL_DEPTH  = GRID_WIDTH * GRID_HEIGHT;

  // port field widths
  localparam int unsigned IN_COL_W   = 6;
  localparam int unsigned IN_ROW_W   = 6;
  localparam int unsigned STATE_W    = 3;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned RANDOM_W   = 16;
  localparam int unsigned CELL_W     = STATE_W + COUNT_W;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // cell state codes
  localparam logic [STATE_W-1:0] ST_OTHER   = 3'd0;
  localparam logic [STATE_W-1:0] ST_LOW     = 3'd1;
  localparam logic [STATE_W-1:0] ST_MEDIUM  = 3'd2;
  localparam logic [STATE_W-1:0] ST_HIGH    = 3'd3;
  localparam logic [STATE_W-1:0] ST_BURNING = 3'd4;
  localparam logic [STATE_W-1:0] ST_BURNT   = 3'd5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
  localparam logic [COUNT_W-1:0] BURN_LIMIT = 4'd3;

  // centre read plus eight neighbours
  localparam int unsigned NB_STEPS = 9;
  localparam int unsigned STEP_W   = $clog2(NB_STEPS + 1);
  localparam int unsigned NB_W     = $clog2(NB_STEPS);

  // width of the ignition compare: 5 * 65535 * 8 fits in 22 bits
  localparam int unsigned CMP_W = 22;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [COUNT_W-1:0] count;
  } cell_t;

  typedef struct packed {
    logic [1:0] dc;
    logic [1:0] dr;
  } offset_t;

  // step 0 is the cell itself, steps 1 to 8 its neighbours
  function automatic offset_t nb_offset(input logic [STEP_W-1:0] step);
    offset_t o;
    unique case (step)
      4'd1:    o = '{dc: 2'b11, dr: 2'b11};
      4'd2:    o = '{dc: 2'b11, dr: 2'b00};
      4'd3:    o = '{dc: 2'b11, dr: 2'b01};
      4'd4:    o = '{dc: 2'b00, dr: 2'b11};
      4'd5:    o = '{dc: 2'b00, dr: 2'b01};
      4'd6:    o = '{dc: 2'b01, dr: 2'b11};
      4'd7:    o = '{dc: 2'b01, dr: 2'b00};
      4'd8:    o = '{dc: 2'b01, dr: 2'b01};
      default: o = '{dc: 2'b00, dr: 2'b00};
    endcase
    return o;
  endfunction

endpackage

// ----- rtl/ffc_ram.sv -----
// ffc_ram: generic single-port synchronous ram, read-first, registered read
// no dependencies
module ffc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/forest_fire_cell_update.sv -----
// forest_fire_cell_update: one cell update of a toroidal forest fire automaton
// depends on ffc_pkg and ffc_ram
//
// The block keeps a 64 x 64 grid of 7-bit cells (state, burn count) in one
// single-port ram with a registered read. A load word writes one cell and
// leaves the block ready for the next word. An evaluate word reads the cell
// and, if it is an unburnt flammable cell, its eight wrap-around neighbours,
// one ram read per cycle, counting the burning ones, then decides ignition by
// an exact integer compare of the random value against the scaled neighbour
// count. The next word is taken only once the block is back in idle, after the
// reads and the decide step, which waits for a free output slot; the single
// ram port, read once per cycle, bounds how fast an evaluation goes. The store is never
// changed by an evaluation. Results sit in an output register, so a new word
// is taken while an earlier result still waits. Cells must be loaded before
// they are read, there is no clearing pass after reset.
module forest_fire_cell_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [ffc_pkg::IN_COL_W-1:0]      in_col,
  input  logic [ffc_pkg::IN_ROW_W-1:0]      in_row,
  input  logic [ffc_pkg::STATE_W-1:0]       in_cell_state,
  input  logic [ffc_pkg::COUNT_W-1:0]       in_cell_burn_count,
  input  logic [ffc_pkg::RANDOM_W-1:0]      in_random_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffc_pkg::STATE_W-1:0]       out_next_state,
  output logic [ffc_pkg::COUNT_W-1:0]       out_next_burn_count
);

  import ffc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_DECIDE = 3'b100
  } fsm_t;

  // control
  fsm_t               state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;        // next read to issue
  logic               rd_pend_r, rd_pend_nxt;  // ram data due this cycle
  logic [STEP_W-1:0]  rd_step_r;               // which read the data belongs to
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [RANDOM_W-1:0] rand_r;
  cell_t               centre_r, centre_nxt;
  logic [NB_W-1:0]     nb_cnt_r, nb_cnt_nxt;
  logic [STATE_W-1:0]  out_state_r, out_state_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  // ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  cell_t             ram_wdata;
  logic [CELL_W-1:0] ram_rdata;
  cell_t             rd_cell;

  // handshake and datapath helpers
  logic              in_accept;
  logic              issue;
  logic              slot_free;
  offset_t           offs;
  logic [COL_W-1:0]  rd_col;
  logic [ROW_W-1:0]  rd_row;
  logic              fire;
  logic [CMP_W-1:0]  scaled_n, scaled_n5;
  logic [CMP_W-1:0]  r8, r10, r32;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign issue     = (state_r == S_READ) && (step_r < STEP_W'(NB_STEPS));
  assign rd_cell   = cell_t'(ram_rdata);

  // neighbour address, wrapping at the grid edges
  always_comb begin
    offs   = nb_offset(step_r);
    rd_col = col_r + {{(COL_W-2){offs.dc[1]}}, offs.dc};
    rd_row = row_r + {{(ROW_W-2){offs.dr[1]}}, offs.dr};
  end

  // ram write on a load word, otherwise read the cell selected by the sequencer
  always_comb begin
    ram_we    = in_accept && (in_operation == OP_LOAD);
    ram_wdata = '{state: in_cell_state, count: in_cell_burn_count};
    if (state_r == S_IDLE) begin
      ram_addr = {in_col[COL_W-1:0], in_row[ROW_W-1:0]};
    end else begin
      ram_addr = {rd_col, rd_row};
    end
  end

  ffc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ignition compare: r/65535 < k*n/8, scaled to integers
  always_comb begin
    scaled_n  = (CMP_W'(nb_cnt_r) << 16) - CMP_W'(nb_cnt_r);  // 65535 * n
    scaled_n5 = (scaled_n << 2) + scaled_n;                    // 5 * 65535 * n
    r8        = CMP_W'(rand_r) << 3;
    r10       = (CMP_W'(rand_r) << 3) + (CMP_W'(rand_r) << 1);
    r32       = CMP_W'(rand_r) << 5;
    case (centre_r.state)
      ST_LOW:    fire = r10 < scaled_n;
      ST_MEDIUM: fire = r8 < scaled_n;
      ST_HIGH:   fire = r32 < scaled_n5;
      default:   fire = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rd_pend_nxt   = 1'b0;
    centre_nxt    = centre_r;
    nb_cnt_nxt    = nb_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_state_nxt = out_state_r;
    out_count_nxt = out_count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_operation == OP_EVAL)) begin
          state_nxt  = S_READ;
          step_nxt   = '0;
          nb_cnt_nxt = '0;
        end
      end

      S_READ: begin
        if (issue) begin
          step_nxt    = step_r + STEP_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          if (rd_step_r == '0) begin
            centre_nxt = rd_cell;
            // only an unburnt flammable cell needs its neighbours
            if (!((rd_cell.state == ST_LOW) || (rd_cell.state == ST_MEDIUM) ||
                  (rd_cell.state == ST_HIGH))) begin
              state_nxt   = S_DECIDE;
              rd_pend_nxt = 1'b0;
            end
          end else begin
            if (rd_cell.state == ST_BURNING) begin
              nb_cnt_nxt = nb_cnt_r + NB_W'(1);
            end
            if (rd_step_r == STEP_W'(NB_STEPS - 1)) begin
              state_nxt = S_DECIDE;
            end
          end
        end
      end

      S_DECIDE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_state_nxt = centre_r.state;
          out_count_nxt = centre_r.count;
          if (centre_r.state == ST_BURNING) begin
            // count saturates, burnt once the stored count reached the limit
            if (centre_r.count != COUNT_MAX) begin
              out_count_nxt = centre_r.count + COUNT_W'(1);
            end
            if (centre_r.count >= BURN_LIMIT) begin
              out_state_nxt = ST_BURNT;
            end
          end else if (fire) begin
            out_state_nxt = ST_BURNING;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      col_r  <= in_col[COL_W-1:0];
      row_r  <= in_row[ROW_W-1:0];
      rand_r <= in_random_value;
    end
    rd_step_r   <= step_r;
    centre_r    <= centre_nxt;
    nb_cnt_r    <= nb_cnt_nxt;
    out_state_r <= out_state_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_next_state      = out_state_r;
  assign out_next_burn_count = out_count_r;

  // the store is only written between evaluations
  a_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("cell ram written during an evaluation");

  // read data only ever lands while the sequencer reads
  a_data_in_read : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_READ))
    else $error("ram read data outside the read phase");

  // never more than eight burning neighbours
  a_nb_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> (nb_cnt_r <= NB_W'(NB_STEPS - 1)))
    else $error("neighbour count out of range");

  // a new result only comes from the decide step
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |->
      ($past(state_r == S_DECIDE) && (state_r == S_IDLE)))
    else $error("result produced outside the decide step");

  // a flammable cell is never decided before all eight neighbours were counted
  a_all_read : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DECIDE) && ((centre_r.state == ST_LOW) ||
      (centre_r.state == ST_MEDIUM) || (centre_r.state == ST_HIGH))) |->
      (step_r == STEP_W'(NB_STEPS)))
    else $error("ignition decided before all neighbours were read");

endmodule
